### rtl/core/xkau_pkg.sv
// Shared types, constants and key helpers for the XOR keystream archive unpacker.
// Used by xkau_engine and xor_keystream_archive_unpacker_top; no dependencies.
package xkau_pkg;

	localparam logic [31:0] SIG_LO       = 32'h5353_4752;
	localparam logic [31:0] SIG_HI       = 32'h0100_4441;
	localparam logic [31:0] SEED_RESET   = 32'hDEAD_CAFE;
	localparam logic [31:0] MAX_NAME_LEN = 32'd256;

	// Parsing phase; the code doubles as the byte kind reported with each result.
	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_NLEN = 3'd1,
		PH_NAME = 3'd2,
		PH_SIZE = 3'd3,
		PH_CONT = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]  plain_byte;
		logic [2:0]  byte_kind;
		logic        field_done;
		logic [31:0] decoded_value;
	} result_t;

	// key * 7 + 3, modulo 2^32
	function automatic logic [31:0] key_next(input logic [31:0] k);
		key_next = (k << 3) - k + 32'd3;
	endfunction

	// little-endian byte of a key word
	function automatic logic [7:0] key_byte(input logic [31:0] k, input logic [1:0] pos);
		unique case (pos)
			2'd0: key_byte = k[7:0];
			2'd1: key_byte = k[15:8];
			2'd2: key_byte = k[23:16];
			default: key_byte = k[31:24];
		endcase
	endfunction

endpackage

### rtl/core/xkau_engine.sv
// Parser state and per-byte decryption for the archive unpacker.
// Depends on xkau_pkg; state advances once per stepped beat.
module xkau_engine
	import xkau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  stream_byte,
	input  logic        archive_start,
	input  logic [31:0] key_seed,
	output result_t     res
);

	phase_t      phase_q, phase_d, ph_eff;
	logic [2:0]  pos_q, pos_d, pos_eff;
	logic [31:0] hkey_q, hkey_d;
	logic [31:0] ckey_q, ckey_d;
	logic [23:0] word_q, word_d, word_eff;
	logic [31:0] rem_q, rem_d, rem_eff;

	logic [7:0]  sig_byte;
	logic        sig_ok;
	logic [31:0] word_value;
	logic        len_too_long;
	logic [31:0] rem_dec;
	logic        rem_last;
	logic [23:0] word_ins;

	// a restart beat parses as the first signature byte
	assign ph_eff   = archive_start ? PH_SIG : phase_q;
	assign pos_eff  = archive_start ? 3'd0 : pos_q;
	assign word_eff = archive_start ? 24'd0 : word_q;
	assign rem_eff  = archive_start ? 32'd0 : rem_q;

	assign sig_byte     = key_byte(pos_eff[2] ? SIG_HI : SIG_LO, pos_eff[1:0]);
	assign sig_ok       = (stream_byte == sig_byte);
	assign word_value   = {stream_byte, word_eff} ^ hkey_q;
	assign len_too_long = (word_value > MAX_NAME_LEN);
	assign rem_dec      = (rem_eff == 32'd0) ? 32'd0 : rem_eff - 32'd1;
	assign rem_last     = (rem_dec == 32'd0);

	always_comb begin
		word_ins = word_eff;
		unique case (pos_eff[1:0])
			2'd0: word_ins[7:0]   = stream_byte;
			2'd1: word_ins[15:8]  = stream_byte;
			2'd2: word_ins[23:16] = stream_byte;
			default: word_ins = word_eff;
		endcase
	end

	// next state
	always_comb begin
		phase_d = ph_eff;
		pos_d   = pos_eff;
		hkey_d  = hkey_q;
		ckey_d  = ckey_q;
		word_d  = word_eff;
		rem_d   = rem_eff;
		unique case (ph_eff)
			PH_SIG: begin
				if (!sig_ok) begin
					phase_d = PH_ERR;
					pos_d   = 3'd0;
				end else if (pos_eff == 3'd7) begin
					phase_d = PH_NLEN;
					pos_d   = 3'd0;
					word_d  = 24'd0;
					hkey_d  = key_seed;
				end else begin
					pos_d = pos_eff + 3'd1;
				end
			end
			PH_NLEN, PH_SIZE: begin
				if (pos_eff[1:0] != 2'd3) begin
					pos_d  = {1'b0, pos_eff[1:0]} + 3'd1;
					word_d = word_ins;
				end else begin
					hkey_d = key_next(hkey_q);
					pos_d  = 3'd0;
					word_d = 24'd0;
					if (ph_eff == PH_NLEN) begin
						if (len_too_long) begin
							phase_d = PH_ERR;
						end else begin
							rem_d   = word_value;
							phase_d = (word_value == 32'd0) ? PH_SIZE : PH_NAME;
						end
					end else begin
						ckey_d  = key_next(hkey_q);
						rem_d   = word_value;
						phase_d = (word_value == 32'd0) ? PH_NLEN : PH_CONT;
					end
				end
			end
			PH_NAME: begin
				hkey_d = key_next(hkey_q);
				rem_d  = rem_dec;
				if (rem_last) begin
					phase_d = PH_SIZE;
					pos_d   = 3'd0;
					word_d  = 24'd0;
				end
			end
			PH_CONT: begin
				if (pos_eff[1:0] == 2'd3) begin
					ckey_d = key_next(ckey_q);
					pos_d  = 3'd0;
				end else begin
					pos_d = {1'b0, pos_eff[1:0]} + 3'd1;
				end
				rem_d = rem_dec;
				if (rem_last) begin
					phase_d = PH_NLEN;
					pos_d   = 3'd0;
					word_d  = 24'd0;
				end
			end
			default: phase_d = PH_ERR;
		endcase
	end

	// outputs
	always_comb begin
		res.plain_byte    = stream_byte;
		res.byte_kind     = PH_ERR;
		res.field_done    = 1'b0;
		res.decoded_value = 32'd0;
		unique case (ph_eff)
			PH_SIG: begin
				if (sig_ok) begin
					res.byte_kind  = PH_SIG;
					res.field_done = (pos_eff == 3'd7);
				end
			end
			PH_NLEN, PH_SIZE: begin
				res.byte_kind  = ph_eff;
				res.plain_byte = stream_byte ^ key_byte(hkey_q, pos_eff[1:0]);
				if (pos_eff[1:0] == 2'd3) begin
					if (ph_eff == PH_NLEN && len_too_long) begin
						// oversize name: report raw byte as an error
						res.byte_kind  = PH_ERR;
						res.plain_byte = stream_byte;
					end else begin
						res.field_done    = 1'b1;
						res.decoded_value = word_value;
					end
				end
			end
			PH_NAME: begin
				res.byte_kind  = PH_NAME;
				res.plain_byte = stream_byte ^ hkey_q[7:0];
				res.field_done = rem_last;
			end
			PH_CONT: begin
				res.byte_kind  = PH_CONT;
				res.plain_byte = stream_byte ^ key_byte(ckey_q, pos_eff[1:0]);
				res.field_done = rem_last;
			end
			default: res.byte_kind = PH_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			pos_q   <= 3'd0;
			hkey_q  <= SEED_RESET;
			ckey_q  <= 32'd0;
			word_q  <= 24'd0;
			rem_q   <= 32'd0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			hkey_q  <= hkey_d;
			ckey_q  <= ckey_d;
			word_q  <= word_d;
			rem_q   <= rem_d;
		end
	end

	// name and content phases always have bytes left to take
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NAME || phase_q == PH_CONT) |-> rem_q != 32'd0)
		else $error("bytes remaining is zero inside a name or content field");

	a_name_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NAME |-> rem_q <= MAX_NAME_LEN)
		else $error("name length above limit accepted");

	a_word_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NLEN || phase_q == PH_SIZE || phase_q == PH_CONT) |-> !pos_q[2])
		else $error("word byte position out of range");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_ERR && !archive_start) |=> phase_q == PH_ERR)
		else $error("left error phase without restart");

endmodule

### rtl/core/xor_keystream_archive_unpacker_top.sv
// Top level of the XOR keystream archive unpacker: input stage, result register,
// key seed register. Depends on xkau_pkg and xkau_engine.
//
// A byte taken into the input register is shown when it steps into the result register.
// Throughput: one byte per cycle; the key step and XOR sit between the input and result
// registers. Backpressure on the result side stalls both stages together.
// Reset: arst_n clears all control state, loads the key seed with 0xDEADCAFE and
// starts parsing at the signature.
module xor_keystream_archive_unpacker_top
	import xkau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	input  logic        archive_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  plain_byte,
	output logic [2:0]  byte_kind,
	output logic        field_done,
	output logic [31:0] decoded_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] key_seed
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	logic [31:0] key_seed_q;
	logic        advance;
	logic        step;

	assign advance   = !valid_s2 || out_ready;
	assign step      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_seed_q <= SEED_RESET;
		end else if (cfg_valid) begin
			key_seed_q <= key_seed;
		end
	end

	// input stage: hold while the result side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= stream_byte;
			start_s1 <= archive_start;
		end
	end

	xkau_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.stream_byte   (byte_s1),
		.archive_start (start_s1),
		.key_seed      (key_seed_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign plain_byte    = res_s2.plain_byte;
	assign byte_kind     = res_s2.byte_kind;
	assign field_done    = res_s2.field_done;
	assign decoded_value = res_s2.decoded_value;

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.byte_kind == PH_ERR) |-> (!res_s2.field_done
			&& res_s2.decoded_value == 32'd0))
		else $error("error beat carries done flag or value");

	a_value_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.decoded_value != 32'd0) |-> (res_s2.field_done
			&& (res_s2.byte_kind == PH_NLEN || res_s2.byte_kind == PH_SIZE)))
		else $error("decoded value outside a completed length or size word");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input beat lost");

endmodule
